@@ rtl/core/rlsg_pkg.sv @@
`timescale 1ns / 1ps

package rlsg_pkg;

   // Strip and hue geometry
   localparam int MAX_LEDS    = 64;
   localparam int HUE_W       = 11;
   localparam int COLOR_W     = 8;
   localparam int LED_INDEX_W = 6;
   localparam int COUNT_W     = 7;
   localparam int STEP_W      = 8;

   localparam logic [HUE_W-1:0]   HUE_MOD   = HUE_W'(1536);
   localparam logic [COLOR_W-1:0] COLOR_MAX = COLOR_W'(255);

   // Register file port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE         = 8'd0,
      CSR_LED_COUNT      = 8'd1,
      CSR_LED_HUE_STEP   = 8'd2,
      CSR_FRAME_HUE_STEP = 8'd3
   } csr_index_type;

   // Wheel segments, one per 256 hue codes
   typedef enum logic [2:0] {
      SEG_RED_UP_GREEN   = 3'd0,
      SEG_RED_DOWN       = 3'd1,
      SEG_BLUE_UP        = 3'd2,
      SEG_GREEN_DOWN     = 3'd3,
      SEG_RED_UP_BLUE    = 3'd4,
      SEG_BLUE_DOWN      = 3'd5
   } wheel_seg_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic start;      // load the first LED hue from the frame hue
      logic emit;       // load one pixel into the output register
      logic frame_adv;  // advance the frame hue
   } ctrl_cmd_type;

   typedef struct packed {
      logic enabled;
      logic count_zero;
      logic slot_free;
      logic last_pixel;
   } dp_status_type;

endpackage

@@ rtl/core/rlsg_req_if.sv @@
`timescale 1ns / 1ps

interface rlsg_req_if;
   logic valid;
   logic ready;
   logic frame_tick;

   modport source (output valid, output frame_tick, input ready);
   modport sink   (input valid, input frame_tick, output ready);
endinterface

@@ rtl/core/rlsg_rsp_if.sv @@
`timescale 1ns / 1ps

interface rlsg_rsp_if import rlsg_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [LED_INDEX_W-1:0] led_index;
   logic [COLOR_W-1:0]     green;
   logic [COLOR_W-1:0]     red;
   logic [COLOR_W-1:0]     blue;
   logic                   last_led;

   modport source (output valid, output led_index, output green, output red,
                   output blue, output last_led, input ready);
   modport sink   (input valid, input led_index, input green, input red,
                   input blue, input last_led, output ready);
endinterface

@@ rtl/core/rlsg_csr_if.sv @@
`timescale 1ns / 1ps

interface rlsg_csr_if import rlsg_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/rlsg_ctrl.sv @@
`timescale 1ns / 1ps

module rlsg_ctrl import rlsg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rlsg_req_if.sink      req_ch,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid && req_ch.frame_tick && status.enabled) begin
               if (status.count_zero) begin
                  cmd.frame_adv = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // emit whenever the output register is free or draining
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.last_pixel) begin
                  cmd.frame_adv = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = req_ready;

endmodule

@@ rtl/core/rlsg_datapath.sv @@
`timescale 1ns / 1ps

module rlsg_datapath import rlsg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rlsg_rsp_if.source    rsp_ch,
   rlsg_csr_if.sink      csr_ch,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   // Add a step below 256 and wrap once into 0..1535
   function automatic logic [HUE_W-1:0] hue_add(input logic [HUE_W-1:0]  hue,
                                               input logic [STEP_W-1:0] step);
      logic [HUE_W-1:0] sum;
      sum = hue + HUE_W'(step);
      if (sum >= HUE_MOD) begin
         sum = sum - HUE_MOD;
      end
      return sum;
   endfunction

   // Configuration registers
   logic              enable_ff;
   logic [COUNT_W-1:0] led_count_ff;
   logic [STEP_W-1:0] led_hue_step_ff;
   logic [STEP_W-1:0] frame_hue_step_ff;

   // Hue state and LED position
   logic [HUE_W-1:0]   frame_hue_ff, frame_hue_in;
   logic [HUE_W-1:0]   led_hue_ff, led_hue_in;
   logic [COUNT_W-1:0] led_pos_ff, led_pos_in;
   logic [COUNT_W-1:0] count_sat;

   // Output register
   logic                   out_valid_ff, out_valid_in;
   logic [LED_INDEX_W-1:0] out_index_ff;
   logic [COLOR_W-1:0]     out_green_ff, out_red_ff, out_blue_ff;
   logic                   out_last_ff;

   logic [COLOR_W-1:0] wheel_r, wheel_g, wheel_b;
   logic [COLOR_W-1:0] frac;
   logic               csr_write;
   logic               is_last;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         led_count_ff      <= COUNT_W'(1);
         led_hue_step_ff   <= '0;
         frame_hue_step_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_ch.index)
            CSR_ENABLE:         enable_ff         <= csr_ch.data[0];
            CSR_LED_COUNT:      led_count_ff      <= csr_ch.data[COUNT_W-1:0];
            CSR_LED_HUE_STEP:   led_hue_step_ff   <= csr_ch.data[STEP_W-1:0];
            CSR_FRAME_HUE_STEP: frame_hue_step_ff <= csr_ch.data[STEP_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // Clamp the LED count to the strip limit
   assign count_sat = (led_count_ff > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS)
                                                          : led_count_ff;
   assign is_last   = ((led_pos_ff + COUNT_W'(1)) == count_sat);

   always_comb begin
      frame_hue_in = frame_hue_ff;
      led_hue_in   = led_hue_ff;
      led_pos_in   = led_pos_ff;
      if (cmd.frame_adv) begin
         frame_hue_in = hue_add(frame_hue_ff, frame_hue_step_ff);
      end
      if (cmd.start) begin
         led_hue_in = frame_hue_ff;
         led_pos_in = '0;
      end else if (cmd.emit) begin
         led_hue_in = hue_add(led_hue_ff, led_hue_step_ff);
         led_pos_in = led_pos_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_hue_ff <= '0;
      end else begin
         frame_hue_ff <= frame_hue_in;
      end
   end

   always_ff @(posedge clock) begin
      led_hue_ff <= led_hue_in;
      led_pos_ff <= led_pos_in;
   end

   // Color wheel
   assign frac = led_hue_ff[COLOR_W-1:0];

   always_comb begin
      case (wheel_seg_type'(led_hue_ff[HUE_W-1:COLOR_W]))
         SEG_RED_UP_GREEN: begin
            wheel_r = COLOR_MAX;        wheel_g = frac;             wheel_b = '0;
         end
         SEG_RED_DOWN: begin
            wheel_r = COLOR_MAX - frac; wheel_g = COLOR_MAX;        wheel_b = '0;
         end
         SEG_BLUE_UP: begin
            wheel_r = '0;               wheel_g = COLOR_MAX;        wheel_b = frac;
         end
         SEG_GREEN_DOWN: begin
            wheel_r = '0;               wheel_g = COLOR_MAX - frac; wheel_b = COLOR_MAX;
         end
         SEG_RED_UP_BLUE: begin
            wheel_r = frac;             wheel_g = '0;               wheel_b = COLOR_MAX;
         end
         default: begin
            wheel_r = COLOR_MAX;        wheel_g = '0;               wheel_b = COLOR_MAX - frac;
         end
      endcase
   end

   // Hold the word until taken, refill in the same cycle it drains
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_index_ff <= led_pos_ff[LED_INDEX_W-1:0];
         out_green_ff <= wheel_g;
         out_red_ff   <= wheel_r;
         out_blue_ff  <= wheel_b;
         out_last_ff  <= is_last;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.led_index = out_index_ff;
   assign rsp_ch.green     = out_green_ff;
   assign rsp_ch.red       = out_red_ff;
   assign rsp_ch.blue      = out_blue_ff;
   assign rsp_ch.last_led  = out_last_ff;

   assign status.enabled    = enable_ff;
   assign status.count_zero = (count_sat == '0);
   assign status.slot_free  = !out_valid_ff || rsp_ch.ready;
   assign status.last_pixel = is_last;

endmodule

@@ rtl/core/rainbow_led_strip_generator.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Word                                      Handshake
// req_ch    in   frame_tick                                valid / ready
// rsp_ch    out  led_index, green, red, blue, last_led     valid / ready
// csr_ch    in   index, data (write only)                  valid / ready
//
// A tick is taken only while no frame is in flight; a frame of N LEDs emits
// one pixel word per cycle while rsp_ch takes them (N up to 64), set by the
// single wheel datapath feeding one output register.
// Synchronous active-high reset clears the FSM, frame hue and config registers (LED count to one).
// A stalled rsp_ch holds the pending pixel and pauses the LED walk.
// csr_ch is always ready.

module rainbow_led_strip_generator import rlsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rlsg_req_if.sink   req_ch,
   rlsg_rsp_if.source rsp_ch,
   rlsg_csr_if.sink   csr_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequence the frame: accept ticks, walk the LEDs, advance the hue
   rlsg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .status (status),
      .cmd    (cmd)
   );

   // Hold config and hue state, map hue to GRB, register the pixel word
   rlsg_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

@@ dv/tb_rainbow_led_strip_generator.sv @@
`timescale 1ns / 1ps

module tb_rainbow_led_strip_generator;
   import rlsg_pkg::*;

   // A frame is at most MAX_LEDS pixel words plus the tick that starts it, so
   // this many quiet cycles cover any pass that emits nothing.
   localparam int SETTLE_CYCLES   = 80;
   // Long output stall, used to back the block up into its input.
   localparam int RSP_HOLD_CYCLES = 400;
   // Quiet cycles with no word moving on any channel before giving up.
   localparam int WATCHDOG_LIMIT  = 3000;
   // Ticks that start a frame in the random part.
   localparam int RANDOM_FRAMES   = 180;

   typedef struct packed {
      logic [LED_INDEX_W-1:0] led_index;
      logic [COLOR_W-1:0]     green;
      logic [COLOR_W-1:0]     red;
      logic [COLOR_W-1:0]     blue;
      logic                   last_led;
   } pixel_word_type;

   logic clock = 1'b0;
   logic reset;

   rlsg_req_if req_ch ();
   rlsg_rsp_if rsp_ch ();
   rlsg_csr_if csr_ch ();

   rainbow_led_strip_generator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // Shadow of the strip registers and the frame hue, as the block should
   // hold them after each accepted word.
   logic                   strip_enable     = 1'b0;
   logic [COUNT_W-1:0]     strip_led_count  = COUNT_W'(1);
   logic [STEP_W-1:0]      strip_led_step   = '0;
   logic [STEP_W-1:0]      strip_frame_step = '0;
   logic [HUE_W-1:0]       strip_frame_hue  = '0;

   pixel_word_type expected_pixels[$];
   int unsigned mismatch_count    = 0;
   int unsigned frames_started    = 0;
   logic        gaps_on           = 1'b1;
   logic        rsp_hold_request  = 1'b0;

   // ------------------------------------------------------------------
   // Color wheel predictor
   // ------------------------------------------------------------------

   // Add a step to a hue and wrap once into 0..1535; one wrap is enough
   // since the step never exceeds 255.
   function automatic logic [HUE_W-1:0] advance_hue(logic [HUE_W-1:0] hue,
                                                    logic [STEP_W-1:0] step);
      logic [HUE_W:0] sum;
      sum = {1'b0, hue} + (HUE_W+1)'(step);
      if (sum >= HUE_MOD) sum = sum - HUE_MOD;
      return sum[HUE_W-1:0];
   endfunction

   // Map a hue onto the six half-open 256-wide segments of the wheel;
   // the low byte of the hue is the ramp within the segment.
   function automatic pixel_word_type wheel_color(logic [HUE_W-1:0] hue);
      pixel_word_type     word;
      logic [COLOR_W-1:0] ramp;
      ramp = hue[COLOR_W-1:0];
      word = '0;
      case (wheel_seg_type'(hue[HUE_W-1:COLOR_W]))
         SEG_RED_UP_GREEN: begin
            word.red = COLOR_MAX;        word.green = ramp;
            word.blue = '0;
         end
         SEG_RED_DOWN: begin
            word.red = COLOR_MAX - ramp; word.green = COLOR_MAX;
            word.blue = '0;
         end
         SEG_BLUE_UP: begin
            word.red = '0;               word.green = COLOR_MAX;
            word.blue = ramp;
         end
         SEG_GREEN_DOWN: begin
            word.red = '0;               word.green = COLOR_MAX - ramp;
            word.blue = COLOR_MAX;
         end
         SEG_RED_UP_BLUE: begin
            word.red = ramp;             word.green = '0;
            word.blue = COLOR_MAX;
         end
         default: begin
            word.red = COLOR_MAX;        word.green = '0;
            word.blue = COLOR_MAX - ramp;
         end
      endcase
      return word;
   endfunction

   // Queue the pixel words of one frame and advance the frame hue. A zero
   // tick or a disabled strip does nothing at all; a zero count emits
   // nothing but still moves the frame hue on. Counts past the strip limit
   // saturate.
   function automatic void predict_frame_pixels(logic tick);
      int unsigned      n_leds;
      logic [HUE_W-1:0] hue;
      pixel_word_type   word;
      if (!tick || !strip_enable) return;
      n_leds = (strip_led_count > MAX_LEDS) ? MAX_LEDS : strip_led_count;
      hue    = strip_frame_hue;
      for (int unsigned i = 0; i < n_leds; i++) begin
         word           = wheel_color(hue);
         word.led_index = LED_INDEX_W'(i);
         word.last_led  = (i + 1 == n_leds);
         expected_pixels.push_back(word);
         hue = advance_hue(hue, strip_led_step);
      end
      strip_frame_hue = advance_hue(strip_frame_hue, strip_frame_step);
      frames_started++;
   endfunction

   // ------------------------------------------------------------------
   // Drivers. Every task is entered and left at a falling edge.
   // ------------------------------------------------------------------

   // Offer one tick word, hold it until taken, then drop valid.
   task automatic send_tick(logic tick);
      while (gaps_on && $urandom_range(99) < 36) @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.frame_tick = tick;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predict_frame_pixels(tick);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Write one register and mirror it into the shadow copy.
   task automatic csr_write(csr_index_type reg_index, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = reg_index;
      csr_ch.data  = value;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      case (reg_index)
         CSR_ENABLE:         strip_enable     = value[0];
         CSR_LED_COUNT:      strip_led_count  = value[COUNT_W-1:0];
         CSR_LED_HUE_STEP:   strip_led_step   = value;
         CSR_FRAME_HUE_STEP: strip_frame_step = value;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_pixels.size() != 0) @(negedge clock);
   endtask

   // Frames that emit nothing leave no trace in the queue, so give the
   // block time to finish one before touching its registers.
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] enable_data,
                            logic [CSR_DATA_W-1:0] count_data,
                            logic [CSR_DATA_W-1:0] led_step,
                            logic [CSR_DATA_W-1:0] frame_step);
      settle();
      csr_write(CSR_ENABLE, enable_data);
      csr_write(CSR_LED_COUNT, count_data);
      csr_write(CSR_LED_HUE_STEP, led_step);
      csr_write(CSR_FRAME_HUE_STEP, frame_step);
   endtask

   // ------------------------------------------------------------------
   // Pixel checker and output flow control
   // ------------------------------------------------------------------

   function automatic void check_field(string field_name, logic [COLOR_W-1:0] want,
                                       logic [COLOR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each pixel word taken with the oldest one predicted.
   always @(posedge clock) begin
      pixel_word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel word at led_index %0d", rsp_ch.led_index);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("led_index", COLOR_W'(want.led_index),
                        COLOR_W'(rsp_ch.led_index));
            check_field("green", want.green, rsp_ch.green);
            check_field("red", want.red, rsp_ch.red);
            check_field("blue", want.blue, rsp_ch.blue);
            check_field("last_led", COLOR_W'(want.last_led),
                        COLOR_W'(rsp_ch.last_led));
         end
      end
   end

   // Drop ready at random, or hold it low for a long stretch on request.
   always @(negedge clock) begin
      int unsigned hold_left;
      if (rsp_hold_request) begin
         hold_left        = RSP_HOLD_CYCLES;
         rsp_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = !(gaps_on && $urandom_range(99) < 36);
      end
   end

   // Stop the run once no word has moved anywhere for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
             (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset the strip is off: a tick emits nothing. Once enabled,
   // the reset count of one gives a single pixel at hue zero.
   task automatic test_reset_state();
      send_tick(1'b1);
      settle();
      csr_write(CSR_ENABLE, 8'h01);
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   // Walk the wheel with the widest steps so hues land on many segment
   // edges and wrap past 1535, then a mid-segment walk.
   task automatic test_segment_edges();
      configure(8'h01, CSR_DATA_W'(MAX_LEDS), 8'd255, 8'd255);
      send_tick(1'b1);
      send_tick(1'b1);
      configure(8'h01, 8'd13, 8'd128, 8'd1);
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   // Zero ticks are ignored and leave the frame hue alone.
   task automatic test_tick_zero();
      configure(8'h01, 8'd5, 8'd200, 8'd37);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   // Disabled strip: nothing comes out and the hue stays frozen.
   task automatic test_disabled();
      configure(8'h00, 8'd4, 8'd60, 8'd90);
      send_tick(1'b1);
      send_tick(1'b1);
      configure(8'h01, 8'd4, 8'd60, 8'd90);
      send_tick(1'b1);
   endtask

   // Zero count: no pixels, yet the frame hue keeps advancing.
   task automatic test_count_zero();
      configure(8'h01, 8'd0, 8'd0, 8'd100);
      send_tick(1'b1);
      send_tick(1'b1);
      configure(8'h01, 8'd3, 8'd0, 8'd0);
      send_tick(1'b1);
   endtask

   // Counts past the strip limit saturate, up to the widest count code.
   task automatic test_count_saturation();
      configure(8'h01, 8'd127, 8'd7, 8'd0);
      send_tick(1'b1);
      configure(8'h01, 8'd65, 8'd0, 8'd255);
      send_tick(1'b1);
   endtask

   // Long stretch with no gaps on either side.
   task automatic test_back_to_back();
      configure(8'h01, 8'd3, 8'd111, 8'd17);
      gaps_on = 1'b0;
      repeat (20) send_tick(1'b1);
      wait_drained();
      gaps_on = 1'b1;
   endtask

   // Stall the output long enough that the block backs up into its input
   // while ticks keep coming.
   task automatic test_output_backpressure();
      configure(8'h01, CSR_DATA_W'(MAX_LEDS), 8'd23, 8'd200);
      @(posedge clock);
      rsp_hold_request = 1'b1;
      @(negedge clock);
      repeat (5) send_tick(1'b1);
   endtask

   // Pause the input until every pixel is out, then resume.
   task automatic test_drain_pause();
      configure(8'h01, 8'd6, 8'd250, 8'd3);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_drained();
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   // Random settings in phases, each followed by a burst of ticks. Counts
   // are mostly short to keep the run brisk; a few phases use the full
   // strip, the saturated codes or zero.
   task automatic test_random_frames();
      int unsigned       frame_goal;
      int unsigned       pick;
      logic [COUNT_W-1:0] count;
      logic [STEP_W-1:0] led_step;
      logic [STEP_W-1:0] frame_step;
      frame_goal = frames_started + RANDOM_FRAMES;
      while (frames_started < frame_goal) begin
         pick = $urandom_range(99);
         if (pick < 60)      count = COUNT_W'($urandom_range(1, 8));
         else if (pick < 85) count = COUNT_W'($urandom_range(9, MAX_LEDS - 1));
         else if (pick < 90) count = COUNT_W'(MAX_LEDS);
         else if (pick < 95) count = COUNT_W'($urandom_range(MAX_LEDS + 1, 127));
         else                count = '0;
         pick = $urandom_range(9);
         led_step = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : STEP_W'($urandom);
         pick = $urandom_range(9);
         frame_step = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : STEP_W'($urandom);
         // Upper data bits are don't-care; toggle them anyway.
         configure({7'($urandom), ($urandom_range(9) != 0)},
                   {1'($urandom), count}, led_step, frame_step);
         repeat ($urandom_range(10, 40)) send_tick($urandom_range(19) != 0);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.frame_tick = 1'b1;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_ENABLE;
      csr_ch.data       = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_segment_edges();
      test_tick_zero();
      test_disabled();
      test_count_zero();
      test_count_saturation();
      test_back_to_back();
      test_output_backpressure();
      test_drain_pause();
      test_random_frames();
      settle();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/rlsg_pkg.sv
rtl/core/rlsg_req_if.sv
rtl/core/rlsg_rsp_if.sv
rtl/core/rlsg_csr_if.sv
rtl/core/rlsg_ctrl.sv
rtl/core/rlsg_datapath.sv
rtl/core/rainbow_led_strip_generator.sv
dv/tb_rainbow_led_strip_generator.sv
